// File: src/bgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_pkg
// Types, register indexes and arithmetic helpers of the glyph placer.
// ----------------------------------------------------------------------------
package bgp_pkg;

  localparam int CODE_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_ADV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSING_ADV = 3'd4;

  localparam logic [15:0] TEXTURE_RST     = 16'hFFFF;
  localparam logic [15:0] SCALE_RST       = 16'd256;
  localparam logic [7:0]  LINE_ADV_RST    = 8'd48;
  localparam logic [7:0]  MISSING_ADV_RST = 8'd16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PLACE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0]        advance;
    logic signed [7:0] off_y;
    logic signed [7:0] off_x;
    logic [7:0]        h;
    logic [7:0]        w;
    logic [11:0]       sy;
    logic [11:0]       sx;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

  typedef struct packed {
    op_e                op;
    logic [7:0]         code;
    logic               fits;
    logic               newline;
    logic               load_ok;
    glyph_t             glyph;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    logic [15:0] texture;
    logic [15:0] scale;
    logic [7:0]  line_adv;
    logic [7:0]  missing_adv;
  } cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [11:0] scale_size(input logic [7:0] size,
                                             input logic [15:0] scale);
    logic [24:0] p;
    logic [11:0] r;
    p = 25'(size) * 25'(scale) + 25'd128;
    if (p[24:8] > 17'd4095) begin
      r = 12'hFFF;
    end else begin
      r = p[19:8];
    end
    return r;
  endfunction

endpackage

// File: src/bgp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bgp_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bgp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_queue
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module bgp_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: src/bgp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_front
// Accept input items, decode the opcode and qualify loads and codes.
// ----------------------------------------------------------------------------
module bgp_front
  import bgp_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         code_i,
  input  logic [11:0]        atlas_x_i,
  input  logic [11:0]        atlas_y_i,
  input  logic [7:0]         glyph_w_i,
  input  logic [7:0]         glyph_h_i,
  input  logic signed [7:0]  offset_x_i,
  input  logic signed [7:0]  offset_y_i,
  input  logic [7:0]         advance_i,
  input  logic signed [15:0] origin_x_i,
  input  logic signed [15:0] origin_y_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  localparam int ExtW = (CODE_BITS > 8) ? CODE_BITS : 8;

  logic [ExtW-1:0] code_ext;
  logic            fits;

  assign code_ext   = ExtW'(code_i);
  assign fits       = ((code_ext >> CODE_BITS) == '0);
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    cmd_o                = '0;
    cmd_o.op             = op_e'(opcode_i);
    cmd_o.code           = code_i;
    cmd_o.fits           = fits;
    cmd_o.newline        = (code_i == NEWLINE_CODE);
    cmd_o.load_ok        = (code_i != '0) && fits && (glyph_w_i != '0) && (glyph_h_i != '0);
    cmd_o.glyph.advance  = advance_i;
    cmd_o.glyph.off_y    = offset_y_i;
    cmd_o.glyph.off_x    = offset_x_i;
    cmd_o.glyph.h        = glyph_h_i;
    cmd_o.glyph.w        = glyph_w_i;
    cmd_o.glyph.sy       = atlas_y_i;
    cmd_o.glyph.sx       = atlas_x_i;
    cmd_o.origin_x       = origin_x_i;
    cmd_o.origin_y       = origin_y_i;
  end

endmodule

// File: src/bgp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_back
// Execute queued commands: glyph table, cursor and the draw output register.
// ----------------------------------------------------------------------------
module bgp_back
  import bgp_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  input  cmd_t               cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] draw_x_o,
  output logic signed [15:0] draw_y_o,
  output logic [11:0]        dest_w_o,
  output logic [11:0]        dest_h_o,
  output logic [11:0]        src_x_o,
  output logic [11:0]        src_y_o,
  output logic [7:0]         src_w_o,
  output logic [7:0]         src_h_o,
  output logic [14:0]        texture_o
);

  localparam int Depth = 1 << CODE_BITS;
  localparam int ExtW  = (CODE_BITS > 8) ? CODE_BITS : 8;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                 state_q, state_d;
  logic [Depth-1:0]     valid_q, valid_d;
  logic                 nonempty_q, nonempty_d;
  logic signed [15:0]   cur_x_q, cur_x_d;
  logic signed [15:0]   cur_y_q, cur_y_d;
  logic signed [15:0]   line_x_q, line_x_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic                 out_free;

  logic signed [15:0]   draw_x_q, draw_y_q;
  logic [11:0]          dest_w_q, dest_h_q, src_x_q, src_y_q;
  logic [7:0]           src_w_q, src_h_q;
  logic [14:0]          texture_q;

  logic [ExtW-1:0]      code_ext;
  logic [CODE_BITS-1:0] idx;
  logic                 ram_en, ram_we;
  logic [GLYPH_W-1:0]   ram_rdata;
  glyph_t               rec;

  assign code_ext = ExtW'(cmd_i.code);
  assign idx      = code_ext[CODE_BITS-1:0];
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_LOOK) && out_free;
  assign rec      = glyph_t'(ram_rdata);

  bgp_ram #(
    .Width(GLYPH_W),
    .Depth(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (idx),
    .wdata_i(cmd_i.glyph),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    nonempty_d = nonempty_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    line_x_d   = line_x_q;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    if (pop_o) begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (cmd_i.load_ok) begin
            ram_en       = 1'b1;
            ram_we       = 1'b1;
            valid_d[idx] = 1'b1;
            nonempty_d   = 1'b1;
          end
        end
        OP_START: begin
          cur_x_d  = cmd_i.origin_x;
          cur_y_d  = cmd_i.origin_y;
          line_x_d = cmd_i.origin_x;
        end
        OP_CLEAR: begin
          valid_d    = '0;
          nonempty_d = 1'b0;
        end
        OP_PLACE: begin
          if (!cfg_i.texture[15] && nonempty_q) begin
            priority if (cmd_i.newline) begin
              cur_x_d = line_x_q;
              cur_y_d = sat16(18'(cur_y_q) + $signed({10'b0, cfg_i.line_adv}));
            end else if (!cmd_i.fits || !valid_q[idx]) begin
              cur_x_d = sat16(18'(cur_x_q) + $signed({10'b0, cfg_i.missing_adv}));
            end else begin
              ram_en  = 1'b1;
              state_d = ST_LOOK;
            end
          end
        end
        default: ;
      endcase
    end
    if (out_load) begin
      cur_x_d = sat16(18'(cur_x_q) + $signed({10'b0, rec.advance}));
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      nonempty_q  <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      line_x_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      nonempty_q  <= nonempty_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      line_x_q    <= line_x_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      draw_x_q  <= sat16(18'(cur_x_q) + 18'(rec.off_x));
      draw_y_q  <= sat16(18'(cur_y_q) + 18'(rec.off_y));
      dest_w_q  <= scale_size(rec.w, cfg_i.scale);
      dest_h_q  <= scale_size(rec.h, cfg_i.scale);
      src_x_q   <= rec.sx;
      src_y_q   <= rec.sy;
      src_w_q   <= rec.w;
      src_h_q   <= rec.h;
      texture_q <= cfg_i.texture[14:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign draw_x_o    = draw_x_q;
  assign draw_y_o    = draw_y_q;
  assign dest_w_o    = dest_w_q;
  assign dest_h_o    = dest_h_q;
  assign src_x_o     = src_x_q;
  assign src_y_o     = src_y_q;
  assign src_w_o     = src_w_q;
  assign src_h_o     = src_h_q;
  assign texture_o   = texture_q;

`ifndef SYNTHESIS
  a_look_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q) |-> $past(ram_en && !ram_we))
    else $error("glyph lookup entered without a table read");

  a_no_pop_in_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK) |-> !pop_o)
    else $error("command taken while a lookup is pending");

  a_out_from_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LOOK))
    else $error("draw item raised outside a lookup");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op == OP_CLEAR) |=> (!nonempty_q && valid_q == '0))
    else $error("clear left glyphs marked valid");
`endif

endmodule

// File: src/bitmap_glyph_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_placer
// Text overlay glyph placer: glyph table, cursor and sprite draw items.
// ----------------------------------------------------------------------------
// A decode front takes one item per cycle into a two-entry command queue, while
// the queue is not full; the execution back drains it. Load, start, clear,
// newline and a code without a glyph complete when they are popped. A drawn
// glyph first reads the glyph table (single-port RAM of 2^CODE_BITS records,
// registered read), then computes and loads the draw output register; that
// load waits while the output stalls with the previous draw held. Valid marks
// are flip-flops, so clear and reset take effect at once, with no sweep.
// ----------------------------------------------------------------------------
module bitmap_glyph_placer
  import bgp_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            code_i,
  input  logic [11:0]           atlas_x_i,
  input  logic [11:0]           atlas_y_i,
  input  logic [7:0]            glyph_w_i,
  input  logic [7:0]            glyph_h_i,
  input  logic signed [7:0]     offset_x_i,
  input  logic signed [7:0]     offset_y_i,
  input  logic [7:0]            advance_i,
  input  logic signed [15:0]    origin_x_i,
  input  logic signed [15:0]    origin_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    draw_x_o,
  output logic signed [15:0]    draw_y_o,
  output logic [11:0]           dest_w_o,
  output logic [11:0]           dest_h_o,
  output logic [11:0]           src_x_o,
  output logic [11:0]           src_y_o,
  output logic [7:0]            src_w_o,
  output logic [7:0]            src_h_o,
  output logic [14:0]           texture_o
);

  cfg_t             cfg_q, cfg_d;
  logic             push, pop, full, empty;
  cmd_t             push_cmd, pop_cmd;
  logic [CMD_W-1:0] pop_bits;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TEXTURE:     cfg_d.texture     = cfg_data_i[15:0];
        CFG_SCALE:       cfg_d.scale       = cfg_data_i[15:0];
        CFG_LINE_ADV:    cfg_d.line_adv    = cfg_data_i[7:0];
        CFG_MISSING_ADV: cfg_d.missing_adv = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.texture     <= TEXTURE_RST;
      cfg_q.scale       <= SCALE_RST;
      cfg_q.line_adv    <= LINE_ADV_RST;
      cfg_q.missing_adv <= MISSING_ADV_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bgp_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .code_i      (code_i),
    .atlas_x_i   (atlas_x_i),
    .atlas_y_i   (atlas_y_i),
    .glyph_w_i   (glyph_w_i),
    .glyph_h_i   (glyph_h_i),
    .offset_x_i  (offset_x_i),
    .offset_y_i  (offset_y_i),
    .advance_i   (advance_i),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .queue_full_i(full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  bgp_queue #(
    .Width(CMD_W),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(pop_bits),
    .empty_o(empty)
  );

  assign pop_cmd = cmd_t'(pop_bits);

  bgp_back #(
    .CODE_BITS(CODE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .draw_x_o   (draw_x_o),
    .draw_y_o   (draw_y_o),
    .dest_w_o   (dest_w_o),
    .dest_h_o   (dest_h_o),
    .src_x_o    (src_x_o),
    .src_y_o    (src_y_o),
    .src_w_o    (src_w_o),
    .src_h_o    (src_h_o),
    .texture_o  (texture_o)
  );

endmodule

// File: test/glyph_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_draw_checker
// Watches the register, item and draw ports of the glyph placer. It keeps its
// own glyph table, cursor and register copies, predicts each sprite draw in
// order and compares every accepted draw field by field with the oldest one.
// ----------------------------------------------------------------------------
module glyph_draw_checker
  import bgp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            code_i,
  input  logic [11:0]           atlas_x_i,
  input  logic [11:0]           atlas_y_i,
  input  logic [7:0]            glyph_w_i,
  input  logic [7:0]            glyph_h_i,
  input  logic signed [7:0]     offset_x_i,
  input  logic signed [7:0]     offset_y_i,
  input  logic [7:0]            advance_i,
  input  logic signed [15:0]    origin_x_i,
  input  logic signed [15:0]    origin_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic signed [15:0]    draw_x_i,
  input  logic signed [15:0]    draw_y_i,
  input  logic [11:0]           dest_w_i,
  input  logic [11:0]           dest_h_i,
  input  logic [11:0]           src_x_i,
  input  logic [11:0]           src_y_i,
  input  logic [7:0]            src_w_i,
  input  logic [7:0]            src_h_i,
  input  logic [14:0]           texture_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    drawn_o
);

  localparam int GLYPH_SLOTS = 2 ** CODE_BITS_DEF;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        dw;
    logic [11:0]        dh;
    logic [11:0]        sx;
    logic [11:0]        sy;
    logic [7:0]         sw;
    logic [7:0]         sh;
    logic [14:0]        tex;
  } draw_t;

  glyph_t             glyph_mem [GLYPH_SLOTS];
  logic               glyph_ok [GLYPH_SLOTS];
  logic               any_glyph;
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic signed [15:0] margin_x;
  logic [15:0]        texture_q;
  logic [15:0]        scale_q;
  logic [7:0]         line_step_q;
  logic [7:0]         miss_step_q;
  draw_t              draw_queue [$];
  int                 mismatches;
  int                 drawn;

  function automatic logic signed [15:0] clamp_s16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic [11:0] scaled_extent(input logic [7:0] size,
                                                input logic [15:0] scale);
    int unsigned prod;
    prod = (int'(size) * int'(scale) + 128) >> 8;
    return (prod > 4095) ? 12'd4095 : 12'(prod);
  endfunction

  task automatic lay_out_item();
    glyph_t g;
    draw_t  d;
    int     idx;
    idx = int'(code_i);
    case (op_e'(opcode_i))
      OP_LOAD: if (code_i != 8'd0 && glyph_w_i != 8'd0 && glyph_h_i != 8'd0) begin
        g.sx      = atlas_x_i;
        g.sy      = atlas_y_i;
        g.w       = glyph_w_i;
        g.h       = glyph_h_i;
        g.off_x   = offset_x_i;
        g.off_y   = offset_y_i;
        g.advance = advance_i;
        glyph_mem[idx] = g;
        glyph_ok[idx]  = 1'b1;
        any_glyph      = 1'b1;
      end
      OP_START: begin
        pen_x    = origin_x_i;
        pen_y    = origin_y_i;
        margin_x = origin_x_i;
      end
      OP_CLEAR: begin
        foreach (glyph_ok[i]) glyph_ok[i] = 1'b0;
        any_glyph = 1'b0;
      end
      default: if (!texture_q[15] && any_glyph) begin
        if (code_i == NEWLINE_CODE) begin
          pen_x = margin_x;
          pen_y = clamp_s16(int'(pen_y) + int'(line_step_q));
        end else if (!glyph_ok[idx]) begin
          pen_x = clamp_s16(int'(pen_x) + int'(miss_step_q));
        end else begin
          g     = glyph_mem[idx];
          d.x   = clamp_s16(int'(pen_x) + int'(g.off_x));
          d.y   = clamp_s16(int'(pen_y) + int'(g.off_y));
          d.dw  = scaled_extent(g.w, scale_q);
          d.dh  = scaled_extent(g.h, scale_q);
          d.sx  = g.sx;
          d.sy  = g.sy;
          d.sw  = g.w;
          d.sh  = g.h;
          d.tex = texture_q[14:0];
          draw_queue.push_back(d);
          pen_x = clamp_s16(int'(pen_x) + int'(g.advance));
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("draw %0d %s: expected %0h, got %0h", drawn, name, want, got);
      end
    end
  endtask

  task automatic check_draw();
    draw_t want;
    if (draw_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected draw at x %0d y %0d src %0h,%0h", draw_x_i, draw_y_i,
                 src_x_i, src_y_i);
      end
    end else begin
      want = draw_queue.pop_front();
      compare_field("draw_x", want.x, draw_x_i);
      compare_field("draw_y", want.y, draw_y_i);
      compare_field("dest_w", 16'(want.dw), 16'(dest_w_i));
      compare_field("dest_h", 16'(want.dh), 16'(dest_h_i));
      compare_field("src_x", 16'(want.sx), 16'(src_x_i));
      compare_field("src_y", 16'(want.sy), 16'(src_y_i));
      compare_field("src_w", 16'(want.sw), 16'(src_w_i));
      compare_field("src_h", 16'(want.sh), 16'(src_h_i));
      compare_field("texture", 16'(want.tex), 16'(texture_i));
    end
    drawn++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (glyph_ok[i]) glyph_ok[i] = 1'b0;
      any_glyph   = 1'b0;
      pen_x       = '0;
      pen_y       = '0;
      margin_x    = '0;
      texture_q   = TEXTURE_RST;
      scale_q     = SCALE_RST;
      line_step_q = LINE_ADV_RST;
      miss_step_q = MISSING_ADV_RST;
      draw_queue.delete();
      mismatches  = 0;
      drawn       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TEXTURE:     texture_q   = cfg_data_i[15:0];
          CFG_SCALE:       scale_q     = cfg_data_i[15:0];
          CFG_LINE_ADV:    line_step_q = cfg_data_i[7:0];
          CFG_MISSING_ADV: miss_step_q = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) lay_out_item();
      if (out_valid_i && !out_stall_i) check_draw();
    end
    fail_count_o <= mismatches;
    pending_o    <= draw_queue.size();
    drawn_o      <= drawn;
  end

endmodule

// File: test/tb_bitmap_glyph_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_glyph_placer
// Drives glyph loads, string starts, characters and table clears into the
// glyph placer under several register settings, with random idle and stall
// bursts on both channels; the draw checker predicts and compares each draw.
// ----------------------------------------------------------------------------
module tb_bitmap_glyph_placer;
  import bgp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 3'd1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct {
    op_e                op;
    logic [7:0]         code;
    logic [11:0]        atlas_x;
    logic [11:0]        atlas_y;
    logic [7:0]         width;
    logic [7:0]         height;
    logic signed [7:0]  off_x;
    logic signed [7:0]  off_y;
    logic [7:0]         advance;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } glyph_cmd_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            opcode_i    = '0;
  logic [7:0]            code_i      = '0;
  logic [11:0]           atlas_x_i   = '0;
  logic [11:0]           atlas_y_i   = '0;
  logic [7:0]            glyph_w_i   = '0;
  logic [7:0]            glyph_h_i   = '0;
  logic signed [7:0]     offset_x_i  = '0;
  logic signed [7:0]     offset_y_i  = '0;
  logic [7:0]            advance_i   = '0;
  logic signed [15:0]    origin_x_i  = '0;
  logic signed [15:0]    origin_y_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [15:0]    draw_x_o;
  logic signed [15:0]    draw_y_o;
  logic [11:0]           dest_w_o;
  logic [11:0]           dest_h_o;
  logic [11:0]           src_x_o;
  logic [11:0]           src_y_o;
  logic [7:0]            src_w_o;
  logic [7:0]            src_h_o;
  logic [14:0]           texture_o;

  int         fail_count;
  int         pending;
  int         drawn;
  logic       quiet = 1'b0;
  int         stall_left = 0;
  int         calm_left = 0;
  int         in_calm = 0;
  int         idle_cycles = 0;
  int         items_sent = 0;
  int         settings_applied = 0;
  logic [7:0] code_pool [$];
  bit         pool_mark [256];

  bitmap_glyph_placer DUT (.*);

  glyph_draw_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .opcode_i     (opcode_i),
    .code_i       (code_i),
    .atlas_x_i    (atlas_x_i),
    .atlas_y_i    (atlas_y_i),
    .glyph_w_i    (glyph_w_i),
    .glyph_h_i    (glyph_h_i),
    .offset_x_i   (offset_x_i),
    .offset_y_i   (offset_y_i),
    .advance_i    (advance_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .draw_x_i     (draw_x_o),
    .draw_y_i     (draw_y_o),
    .dest_w_i     (dest_w_o),
    .dest_h_i     (dest_h_o),
    .src_x_i      (src_x_o),
    .src_y_i      (src_y_o),
    .src_w_i      (src_w_o),
    .src_h_i      (src_h_o),
    .texture_i    (texture_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .drawn_o      (drawn)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left   <= calm_left - 1;
      out_stall_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet && $urandom_range(0, 29) == 0) calm_left <= $urandom_range(20, 80);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic glyph_cmd_t random_fields();
    glyph_cmd_t c;
    c.op       = op_e'($urandom_range(0, 3));
    c.code     = 8'($urandom);
    c.atlas_x  = 12'($urandom);
    c.atlas_y  = 12'($urandom);
    c.width    = 8'($urandom);
    c.height   = 8'($urandom);
    c.off_x    = 8'($urandom);
    c.off_y    = 8'($urandom);
    c.advance  = 8'($urandom);
    c.origin_x = 16'($urandom);
    c.origin_y = 16'($urandom);
    return c;
  endfunction

  function automatic glyph_cmd_t glyph_load(input logic [7:0] code, input logic [11:0] ax,
                                            input logic [11:0] ay, input logic [7:0] w,
                                            input logic [7:0] h, input logic [7:0] ox,
                                            input logic [7:0] oy, input logic [7:0] adv);
    glyph_cmd_t c;
    c         = random_fields();
    c.op      = OP_LOAD;
    c.code    = code;
    c.atlas_x = ax;
    c.atlas_y = ay;
    c.width   = w;
    c.height  = h;
    c.off_x   = ox;
    c.off_y   = oy;
    c.advance = adv;
    return c;
  endfunction

  function automatic glyph_cmd_t text_op(input op_e op, input logic [7:0] code);
    glyph_cmd_t c;
    c      = random_fields();
    c.op   = op;
    c.code = code;
    return c;
  endfunction

  function automatic glyph_cmd_t start_at(input logic [15:0] x, input logic [15:0] y);
    glyph_cmd_t c;
    c          = random_fields();
    c.op       = OP_START;
    c.origin_x = x;
    c.origin_y = y;
    return c;
  endfunction

  function automatic glyph_cmd_t pick_random_item();
    glyph_cmd_t c;
    int         roll;
    c    = random_fields();
    roll = $urandom_range(0, 99);
    if (roll < 14 || code_pool.size() < 4) begin
      c.op = OP_LOAD;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       c.code   = 8'd0;
          1:       c.width  = 8'd0;
          default: c.height = 8'd0;
        endcase
      end
    end else if (roll < 19) begin
      c.op = OP_START;
      if ($urandom_range(0, 3) != 0) begin
        c.origin_x = 16'(int'($urandom_range(0, 4000)) - 2000);
        c.origin_y = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
    end else if (roll < 20) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_PLACE;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        c.code = code_pool[$urandom_range(0, code_pool.size() - 1)];
      end else if (roll < 78) begin
        c.code = NEWLINE_CODE;
      end
    end
    return c;
  endfunction

  task automatic send_item(input glyph_cmd_t c);
    int gap;
    gap = 0;
    if (in_calm > 0) begin
      in_calm--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
    end else if (!quiet && $urandom_range(0, 39) == 0) begin
      in_calm = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= c.op;
    code_i     <= c.code;
    atlas_x_i  <= c.atlas_x;
    atlas_y_i  <= c.atlas_y;
    glyph_w_i  <= c.width;
    glyph_h_i  <= c.height;
    offset_x_i <= c.off_x;
    offset_y_i <= c.off_y;
    advance_i  <= c.advance;
    origin_x_i <= c.origin_x;
    origin_y_i <= c.origin_y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (c.op == OP_LOAD && c.code != 8'd0 && c.width != 8'd0 && c.height != 8'd0) begin
      if (!pool_mark[c.code]) begin
        pool_mark[c.code] = 1'b1;
        code_pool.push_back(c.code);
      end
    end else if (c.op == OP_CLEAR) begin
      code_pool.delete();
      foreach (pool_mark[i]) pool_mark[i] = 1'b0;
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [15:0] tex, input logic [31:0] color,
                               input logic [15:0] scale, input logic [7:0] line_step,
                               input logic [7:0] miss_step);
    logic [CFG_IDX_W-1:0]  idxs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idxs = '{CFG_TEXTURE, CFG_COLOR, CFG_SCALE, CFG_LINE_ADV, CFG_MISSING_ADV};
    vals = '{{16'($urandom), tex}, color, {16'($urandom), scale},
             {24'($urandom), line_step}, {24'($urandom), miss_step}};
    foreach (idxs[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int count;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(text_op(OP_PLACE, 8'd66));
    send_item(glyph_load(8'd0, 12'd1, 12'd2, 8'd5, 8'd5, 8'd0, 8'd0, 8'd4));
    send_item(glyph_load(8'd65, 12'd1, 12'd2, 8'd0, 8'd5, 8'd0, 8'd0, 8'd4));
    send_item(glyph_load(8'd65, 12'd1, 12'd2, 8'd5, 8'd0, 8'd0, 8'd0, 8'd4));
    send_item(text_op(OP_PLACE, 8'd65));
    send_item(glyph_load(8'd65, 12'd10, 12'd20, 8'd8, 8'd12, 8'sd1, -8'sd2, 8'd9));
    send_item(text_op(OP_PLACE, 8'd65));
    send_item(start_at(16'sd100, 16'sd200));
    settle();
    apply_setting(16'd5, 32'h1234_5678, 16'd256, 8'd48, 8'd16);

    send_item(text_op(OP_PLACE, 8'd65));
    send_item(text_op(OP_PLACE, NEWLINE_CODE));
    send_item(text_op(OP_PLACE, 8'd200));
    send_item(glyph_load(NEWLINE_CODE, 12'd3, 12'd3, 8'd3, 8'd3, 8'd0, 8'd0, 8'd3));
    send_item(text_op(OP_PLACE, NEWLINE_CODE));
    send_item(glyph_load(8'd255, 12'hFFF, 12'hFFF, 8'd255, 8'd255, 8'h80, 8'h80, 8'd255));
    send_item(glyph_load(8'd254, 12'd0, 12'd0, 8'd1, 8'd1, 8'h7F, 8'h7F, 8'd255));
    send_item(start_at(16'sh7FFF, 16'sh8000));
    send_item(text_op(OP_PLACE, 8'd254));
    send_item(text_op(OP_PLACE, 8'd255));
    send_item(text_op(OP_PLACE, 8'd200));
    send_item(start_at(16'sh8000, 16'sh7FFF));
    send_item(text_op(OP_PLACE, 8'd255));
    send_item(text_op(OP_PLACE, NEWLINE_CODE));
    send_item(text_op(OP_CLEAR, 8'd0));
    send_item(text_op(OP_PLACE, 8'd65));
    send_item(glyph_load(8'd65, 12'd10, 12'd20, 8'd8, 8'd12, 8'sd1, -8'sd2, 8'd9));
    send_item(text_op(OP_PLACE, 8'd65));

    for (int p = 0; p < 7; p++) begin
      settle();
      case (p)
        0: apply_setting(16'd1, $urandom, 16'd256, 8'd48, 8'd16);
        1: apply_setting(16'h7FFF, 32'h0, 16'd0, 8'd0, 8'd0);
        2: apply_setting(16'($urandom_range(0, 32767)), 32'hFFFF_FFFF, 16'hFFFF, 8'd255,
                         8'd255);
        3: apply_setting(16'h8000, $urandom, 16'($urandom), 8'($urandom), 8'($urandom));
        default: apply_setting(16'($urandom_range(0, 32767)), $urandom,
                               16'($urandom_range(0, 1023)), 8'($urandom), 8'($urandom));
      endcase
      if (p == 6) quiet <= 1'b1;
      count = (p == 3) ? 80 : 220;
      repeat (count) send_item(pick_random_item());
    end
    settle();

    $display("sent %0d items (loads, starts, characters, clears) over %0d register settings",
             items_sent, settings_applied);
    $display("compared %0d glyph draws against the prediction", drawn);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/bgp_pkg.sv
src/bgp_ram.sv
src/bgp_queue.sv
src/bgp_front.sv
src/bgp_back.sv
src/bitmap_glyph_placer.sv
test/glyph_draw_checker.sv
test/tb_bitmap_glyph_placer.sv
